/* hdl/rmsi_pkg.sv */
package rmsi_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MED_W    = 33;
    localparam int CNT_W    = 11;
    localparam int OUT_W    = 48;

    localparam int MED_LSB  = 0;
    localparam int CNT_LSB  = MED_W;
    localparam int OVF_BIT  = MED_W + CNT_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MED_W-1:0]    t_median;
    typedef logic        [CNT_W-1:0]    t_count_out;
    typedef logic        [OUT_W-1:0]    t_out_data;

endpackage

/* hdl/rmsi_cell.sv */
module rmsi_cell #(
    parameter int IDX = 0,
    parameter int CW  = 11
) (
    input  logic               i_clk,
    input  logic               i_ins,
    input  rmsi_pkg::t_sample  i_key,
    input  logic [CW-1:0]      i_count,
    input  rmsi_pkg::t_sample  i_left_val,
    input  logic               i_left_gt,
    output rmsi_pkg::t_sample  o_val,
    output logic               o_gt
);

    rmsi_pkg::t_sample r_val;
    rmsi_pkg::t_sample n_val;

    // an empty slot counts as greater, so it takes the shifted or new value
    assign o_gt  = (i_count <= CW'(IDX)) || (r_val > i_key);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (o_gt) begin
            n_val = i_left_gt ? i_left_val : i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            r_val <= n_val;
        end
    end

endmodule

/* hdl/running_median_sorted_insert.sv */
// Pipeline: insert at request accept, median select, add into the result register.
// Requests are not taken back to back; the cell row is read by the median
// select in the cycle after an insert, so the next insert waits; a stalled output also holds it off.
// A full store drops the sample and reports overflow with the unchanged median.
// Reset (synchronous, active low) clears the count and all pipeline valids;
// the cell contents are not cleared.
module running_median_sorted_insert #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // [32:0] median_doubled, [43:33] count_held,
                                         // [44] overflow, [47:45] zero
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);

    rmsi_pkg::t_sample w_val [STORE_DEPTH];
    logic              w_gt  [STORE_DEPTH];

    logic [CW-1:0] r_count;
    logic          r_s1_vld;
    logic          r_s1_ovf;
    logic          r_s2_vld;
    logic          r_s2_ovf;
    rmsi_pkg::t_sample r_s2_a;
    rmsi_pkg::t_sample r_s2_b;
    rmsi_pkg::t_count_out r_s2_cnt;
    logic          r_out_vld;
    rmsi_pkg::t_median    r_out_med;
    rmsi_pkg::t_count_out r_out_cnt;
    logic          r_out_ovf;

    logic          w_accept;
    logic          w_full;
    logic          w_ins;
    logic          w_s2_adv;
    logic [AW-1:0] w_idx_a;
    logic [AW-1:0] w_idx_b;
    logic [CW-1:0] w_half;
    rmsi_pkg::t_sample w_key;

    assign w_key    = rmsi_pkg::t_sample'(i_s_axis_tdata);
    assign w_full   = (r_count == CW'(STORE_DEPTH));
    assign w_s2_adv = r_s2_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_vld && (!r_s2_vld || w_s2_adv);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ins    = w_accept && !w_full;

    genvar g;
    generate
        for (g = 0; g < STORE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                rmsi_cell #(.IDX(g), .CW(CW)) u_cell (
                    .i_clk      (i_clk),
                    .i_ins      (w_ins),
                    .i_key      (w_key),
                    .i_count    (r_count),
                    .i_left_val (w_key),
                    .i_left_gt  (1'b0),
                    .o_val      (w_val[g]),
                    .o_gt       (w_gt[g])
                );
            end else begin : g_rest
                rmsi_cell #(.IDX(g), .CW(CW)) u_cell (
                    .i_clk      (i_clk),
                    .i_ins      (w_ins),
                    .i_key      (w_key),
                    .i_count    (r_count),
                    .i_left_val (w_val[g-1]),
                    .i_left_gt  (w_gt[g-1]),
                    .o_val      (w_val[g]),
                    .o_gt       (w_gt[g])
                );
            end
        end
    endgenerate

    assign w_half  = r_count >> 1;
    assign w_idx_a = w_half[AW-1:0];
    assign w_idx_b = r_count[0] ? w_half[AW-1:0] : AW'(w_half - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_ins) begin
                r_count <= r_count + CW'(1);
            end
            r_s1_vld <= w_accept;
            if (r_s1_vld) begin
                r_s2_vld <= 1'b1;
            end else if (w_s2_adv) begin
                r_s2_vld <= 1'b0;
            end
            if (w_s2_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ovf <= w_full;
        end
        if (r_s1_vld) begin
            r_s2_a   <= w_val[w_idx_a];
            r_s2_b   <= w_val[w_idx_b];
            r_s2_ovf <= r_s1_ovf;
            r_s2_cnt <= rmsi_pkg::CNT_W'(r_count);
        end
        if (w_s2_adv) begin
            r_out_med <= rmsi_pkg::t_median'(r_s2_a) + rmsi_pkg::t_median'(r_s2_b);
            r_out_cnt <= r_s2_cnt;
            r_out_ovf <= r_s2_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {3'b000, r_out_ovf, r_out_cnt, r_out_med};

endmodule

/* hdl/rmsi_checker.sv */
module rmsi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_gap_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken in cycle after insert");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[rmsi_pkg::OVF_BIT-1:rmsi_pkg::CNT_LSB] != '0)
        else $error("result with empty store");

endmodule

bind running_median_sorted_insert rmsi_checker u_rmsi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* test/running_median_sorted_insert_tb.sv */
`timescale 1ns / 1ps

module running_median_sorted_insert_tb;

    localparam int STORE_DEPTH    = 1024;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PRINT_CAP      = 40;

    localparam rmsi_pkg::t_sample SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam rmsi_pkg::t_sample SAMPLE_MIN = 32'sh8000_0000;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_SPARSE} t_rx_mode;

    typedef struct {
        rmsi_pkg::t_median    median_doubled;
        rmsi_pkg::t_count_out count_held;
        logic                 overflow;
    } t_median_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;  // [31:0] sample
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;        // [32:0] median_doubled, [43:33] count_held,
                                        // [44] overflow, [47:45] zero

    rmsi_pkg::t_sample held_samples[$];
    t_median_result    median_q[$];

    int       err_cnt     = 0;
    int       sent_cnt    = 0;
    int       drop_cnt    = 0;
    int       checked_cnt = 0;
    int       burst_left  = 0;
    int       hold_asked  = 0;
    int       hold_served = 0;
    int       hold_left   = 0;
    int       held_cycles = 0;
    int       seg_left    = 0;
    t_rx_mode rx_mode     = RX_OPEN;
    int       cycle_cnt   = 0;

    running_median_sorted_insert #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // insert after equal entries, then take twice the median of what is held
    function automatic t_median_result insert_and_median(input rmsi_pkg::t_sample s);
        t_median_result r;
        int             pos;
        int             n;
        longint         twice;
        r.overflow = (held_samples.size() >= STORE_DEPTH);
        if (!r.overflow) begin
            pos = 0;
            while (pos < held_samples.size() && held_samples[pos] <= s)
                pos++;
            held_samples.insert(pos, s);
        end
        n = held_samples.size();
        if (n == 0)
            twice = 0;
        else if (n % 2 == 1)
            twice = 2 * longint'(held_samples[n / 2]);
        else
            twice = longint'(held_samples[n / 2]) + longint'(held_samples[n / 2 - 1]);
        r.median_doubled = rmsi_pkg::t_median'(twice);
        r.count_held     = rmsi_pkg::t_count_out'(n);
        return r;
    endfunction

    function automatic rmsi_pkg::t_sample pick_sample();
        int n;
        n = held_samples.size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return rmsi_pkg::t_sample'($urandom);
            4, 5:       return rmsi_pkg::t_sample'(int'($urandom_range(0, 16)) - 8);
            6: begin
                if ($urandom_range(0, 1))
                    return SAMPLE_MAX - rmsi_pkg::t_sample'($urandom_range(0, 3));
                return SAMPLE_MIN + rmsi_pkg::t_sample'($urandom_range(0, 3));
            end
            default: begin
                if (n == 0)
                    return rmsi_pkg::t_sample'($urandom);
                return held_samples[n / 2]
                       + rmsi_pkg::t_sample'(int'($urandom_range(0, 4)) - 2);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic push_sample(input rmsi_pkg::t_sample s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!(i_s_axis_tvalid && o_s_axis_tready))
            @(posedge i_clk);
        burst_left--;
        sent_cnt++;
        median_q.push_back(insert_and_median(s));
        if (median_q[$].overflow)
            drop_cnt++;
    endtask

    always @(posedge i_clk) begin : rx_pace
        logic rdy;
        if (hold_left == 0 && hold_served != hold_asked) begin
            hold_served++;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            held_cycles++;
            rdy = 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(4, 60);
                rx_mode  = t_rx_mode'($urandom_range(0, 3));
            end
            seg_left--;
            case (rx_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
                RX_HALF:   rdy = $urandom_range(0, 1);
                default:   rdy = ($urandom_range(0, 3) == 0);
            endcase
        end
        i_m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin : median_check
        t_median_result       want;
        rmsi_pkg::t_median    got_median;
        rmsi_pkg::t_count_out got_count;
        logic                 got_ovf;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_median = o_m_axis_tdata[rmsi_pkg::MED_LSB +: rmsi_pkg::MED_W];
            got_count  = o_m_axis_tdata[rmsi_pkg::CNT_LSB +: rmsi_pkg::CNT_W];
            got_ovf    = o_m_axis_tdata[rmsi_pkg::OVF_BIT];
            if (median_q.size() == 0) begin
                report_mismatch($sformatf("result with none pending, tdata=%h", o_m_axis_tdata));
            end else begin
                want = median_q.pop_front();
                checked_cnt++;
                if (got_median !== want.median_doubled)
                    report_mismatch($sformatf("median_doubled got %0d want %0d",
                                              got_median, want.median_doubled));
                if (got_count !== want.count_held)
                    report_mismatch($sformatf("count_held got %0d want %0d",
                                              got_count, want.count_held));
                if (got_ovf !== want.overflow)
                    report_mismatch($sformatf("overflow got %b want %b",
                                              got_ovf, want.overflow));
            end
        end
    end

    task automatic test_extremes();
        rmsi_pkg::t_sample seq[$];
        seq = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                32'sd0, -32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sh5555_5555,
                32'shAAAA_AAAA, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX - 1, SAMPLE_MIN + 1,
                -32'sd1, 32'sd0, 32'sd1};
        foreach (seq[k])
            push_sample(seq[k]);
    endtask

    task automatic test_random_fill(input int n_items);
        repeat (n_items)
            push_sample(pick_sample());
    endtask

    // hold the output while requests keep coming so the input backs up
    task automatic test_output_hold();
        hold_asked++;
        burst_left = 64;
        repeat (48)
            push_sample(pick_sample());
    endtask

    task automatic test_full_store();
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(32'sd0);
        repeat (23)
            push_sample(pick_sample());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_random_fill(400);
        test_output_hold();
        test_random_fill(STORE_DEPTH - held_samples.size());
        test_full_store();

        i_s_axis_tvalid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples and checked %0d medians; %0d samples hit a full store.",
                 sent_cnt, checked_cnt, drop_cnt);
        $display("Output held off for %0d cycles in total, with extreme and repeated values.",
                 held_cycles);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
